// File: rtl/hysteresis_ascent_accumulator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hysteresis ascent accumulator
// Shared implication checks, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_ASCENT_ACCUMULATOR_MACROS_SVH
`define HYSTERESIS_ASCENT_ACCUMULATOR_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define HAA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hysteresis ascent accumulator: same-cycle check failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define HAA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hysteresis ascent accumulator: next-cycle check failed");

`endif

// File: rtl/haa_pkg.sv
// ----------------------------------------------------------------------------
// haa_pkg
// Types and constants shared by the hysteresis ascent accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package haa_pkg;

	localparam int unsigned ELE_W = 25;
	localparam int unsigned THR_W = 20;
	localparam int unsigned SUM_W = 40;

	localparam logic [THR_W-1:0] THR_RST = 20'd500;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEEK,
		PH_TRACK
	} phase_t;

	typedef struct packed {
		logic signed [ELE_W-1:0] elevation;
		logic                    last_sample;
	} in_t;

	typedef struct packed {
		logic [SUM_W-1:0] total_ascent;
		logic             saturated;
	} out_t;

	typedef struct packed {
		phase_t                  phase;
		logic signed [ELE_W-1:0] last_ext;
		logic signed [ELE_W-1:0] run_ext;
		logic                    going_up;
		logic [SUM_W-1:0]        sum;
		logic                    sum_sat;
	} track_t;

	localparam track_t TRACK_RST = '{
		phase:    PH_IDLE,
		last_ext: '0,
		run_ext:  '0,
		going_up: 1'b0,
		sum:      '0,
		sum_sat:  1'b0
	};

endpackage

`default_nettype wire

// File: rtl/haa_step.sv
// ----------------------------------------------------------------------------
// haa_step
// Next-state logic for one elevation sample: seek, track, rise accumulation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module haa_step (
	input  haa_pkg::track_t            cur,
	input  haa_pkg::in_t               item,
	input  logic [haa_pkg::THR_W-1:0]  thr,
	output haa_pkg::track_t            nxt,
	output haa_pkg::out_t              res
);
	import haa_pkg::*;

	logic signed [ELE_W:0]   diff;
	logic [ELE_W:0]          mag;
	logic                    beyond;
	logic                    extend;
	logic                    add_en;
	logic signed [ELE_W-1:0] rise_hi;
	logic signed [ELE_W-1:0] rise_lo;
	logic signed [ELE_W:0]   rise;
	logic [SUM_W:0]          total;
	track_t                  mid;

	always_comb begin
		mid     = cur;
		add_en  = 1'b0;
		rise_hi = cur.run_ext;
		rise_lo = cur.last_ext;
		extend  = cur.going_up ? (item.elevation > cur.run_ext)
		                       : (item.elevation < cur.run_ext);
		// seek measures from the start level, track from the running extremum
		if (cur.phase == PH_SEEK) begin
			diff = {item.elevation[ELE_W-1], item.elevation}
			     - {cur.last_ext[ELE_W-1], cur.last_ext};
		end else begin
			diff = {item.elevation[ELE_W-1], item.elevation}
			     - {cur.run_ext[ELE_W-1], cur.run_ext};
		end
		mag    = diff[ELE_W] ? -diff : diff;
		beyond = mag > {{(ELE_W+1-THR_W){1'b0}}, thr};

		case (cur.phase)
			PH_SEEK: begin
				if (beyond) begin
					mid.run_ext  = item.elevation;
					mid.going_up = !diff[ELE_W] && (diff != '0);
					mid.phase    = PH_TRACK;
				end
			end
			PH_TRACK: begin
				if (extend) begin
					mid.run_ext = item.elevation;
				end else if (beyond) begin
					// close the leg; a finished rise goes to the total
					add_en       = cur.going_up;
					mid.last_ext = cur.run_ext;
					mid.run_ext  = item.elevation;
					mid.going_up = !cur.going_up;
				end
			end
			default: begin
				mid          = TRACK_RST;
				mid.last_ext = item.elevation;
				mid.phase    = PH_SEEK;
			end
		endcase

		// the ending sample adds the pending rise; never on the same sample as a leg-close add
		if (item.last_sample && (mid.phase == PH_TRACK) && mid.going_up) begin
			add_en  = 1'b1;
			rise_hi = mid.run_ext;
			rise_lo = mid.last_ext;
		end

		rise  = {rise_hi[ELE_W-1], rise_hi} - {rise_lo[ELE_W-1], rise_lo};
		total = {1'b0, mid.sum} + {{(SUM_W-ELE_W){1'b0}}, rise};
		nxt   = mid;
		if (add_en && !rise[ELE_W] && (rise != '0)) begin
			if (total[SUM_W]) begin
				nxt.sum     = SUM_MAX;
				nxt.sum_sat = 1'b1;
			end else begin
				nxt.sum = total[SUM_W-1:0];
			end
		end

		res.total_ascent = nxt.sum;
		res.saturated    = nxt.sum_sat;
	end

endmodule

`default_nettype wire

// File: rtl/hysteresis_ascent_accumulator.sv
// ----------------------------------------------------------------------------
// hysteresis_ascent_accumulator
// Total climb of an elevation track with hysteresis on direction changes.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in      | in        | in_valid/in_stall   | elevation, last_sample
//   out     | out       | out_valid/out_stall | total_ascent, saturated
//   cfg     | in        | cfg_valid/cfg_ready | hysteresis_threshold
//
// One sample per cycle, unless a last sample waits on a stalled result. A
// sample is registered in the input register, then the seek/track/add logic
// updates the track state and, on the last sample, loads the result register.
// The track state loop (compare, one 40-bit add) bounds the clock.
// Reset clears the track state and sets the threshold to 500.
// A stalled result holds only a last sample; other samples keep flowing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hysteresis_ascent_accumulator_macros.svh"

module hysteresis_ascent_accumulator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  haa_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output haa_pkg::out_t             out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [haa_pkg::THR_W-1:0] cfg_data
);
	import haa_pkg::*;

	in_t              item_s1;
	logic             valid_s1;
	track_t           trk_q;
	logic [THR_W-1:0] thr_q;
	out_t             res_q;
	logic             res_valid_q;

	track_t           trk_nxt;
	out_t             res_nxt;
	logic             out_free;
	logic             advance;

	haa_step u_step (
		.cur  (trk_q),
		.item (item_s1),
		.thr  (thr_q),
		.nxt  (trk_nxt),
		.res  (res_nxt)
	);

	assign out_free  = !res_valid_q || !out_stall;
	assign advance   = valid_s1 && (!item_s1.last_sample || out_free);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			trk_q       <= TRACK_RST;
			thr_q       <= THR_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				// a finished track leaves everything at its reset value
				trk_q <= item_s1.last_sample ? TRACK_RST : trk_nxt;
			end
			if (advance && item_s1.last_sample) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (advance && item_s1.last_sample) begin
			res_q <= res_nxt;
		end
	end

	`HAA_ASSERT_SAME(a_sat_at_max, clk, arst_n, res_valid_q && res_q.saturated, res_q.total_ascent == SUM_MAX)
	`HAA_ASSERT_SAME(a_trk_sat_at_max, clk, arst_n, trk_q.sum_sat, trk_q.sum == SUM_MAX)
	`HAA_ASSERT_NEXT(a_end_to_idle, clk, arst_n, advance && item_s1.last_sample, (trk_q.phase == PH_IDLE) && res_valid_q)
	`HAA_ASSERT_NEXT(a_start_seeks, clk, arst_n, advance && !item_s1.last_sample && (trk_q.phase == PH_IDLE), trk_q.phase == PH_SEEK)
	`HAA_ASSERT_SAME(a_stall_needs_last, clk, arst_n, in_stall, valid_s1 && item_s1.last_sample && res_valid_q)

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hysteresis ascent accumulator. A short table of
// hand-picked tracks runs first, then random tracks under several threshold
// settings. Every result is checked against a typed value or a cycle-free
// model of the climb logic.
// ----------------------------------------------------------------------------
module tb;
	import haa_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int TRACK_BUDGET = 320;

	typedef struct {
		in_t  smp;
		bit   typed;
		out_t want;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_t             out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [THR_W-1:0] cfg_data = '0;

	// model state of the climb logic
	logic [THR_W-1:0] thr_m = THR_RST;
	track_t           trk_m = TRACK_RST;
	out_t             totals_q[$];
	row_t             rows[$];

	int errors = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;

	hysteresis_ascent_accumulator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function void add_leg_rise();
		longint rise;
		rise = longint'(trk_m.run_ext) - longint'(trk_m.last_ext);
		if (rise > 0) begin
			if (64'(rise) > 64'(SUM_MAX - trk_m.sum)) begin
				trk_m.sum = SUM_MAX;
				trk_m.sum_sat = 1'b1;
			end else begin
				trk_m.sum = trk_m.sum + rise[SUM_W-1:0];
			end
		end
	endfunction

	// Advance the model by one sample; return 1 when it closes a track.
	function bit climb_step(input in_t s, output out_t r);
		longint ele;
		longint diff;
		longint lim;
		ele = longint'(s.elevation);
		lim = longint'(thr_m);
		r = '0;
		case (trk_m.phase)
			PH_SEEK: begin
				diff = ele - longint'(trk_m.last_ext);
				if ((diff < 0 ? -diff : diff) > lim) begin
					trk_m.run_ext = s.elevation;
					trk_m.going_up = diff > 0;
					trk_m.phase = PH_TRACK;
				end
			end
			PH_TRACK: begin
				if (trk_m.going_up ? (ele > longint'(trk_m.run_ext))
						: (ele < longint'(trk_m.run_ext))) begin
					trk_m.run_ext = s.elevation;
				end else begin
					diff = ele - longint'(trk_m.run_ext);
					if ((diff < 0 ? -diff : diff) > lim) begin
						if (trk_m.going_up)
							add_leg_rise();
						trk_m.last_ext = trk_m.run_ext;
						trk_m.run_ext = s.elevation;
						trk_m.going_up = !trk_m.going_up;
					end
				end
			end
			default: begin
				trk_m = TRACK_RST;
				trk_m.last_ext = s.elevation;
				trk_m.phase = PH_SEEK;
			end
		endcase
		if (!s.last_sample)
			return 1'b0;
		if (trk_m.phase == PH_TRACK && trk_m.going_up)
			add_leg_rise();
		r.total_ascent = trk_m.sum;
		r.saturated = trk_m.sum_sat;
		trk_m = TRACK_RST;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		if (errors <= 100)
			$display("%0t %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// check results as they are taken; track register writes
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (totals_q.size() == 0) begin
					report_mismatch("result with nothing pending", 64'(out_data), 64'(0));
				end else begin
					want = totals_q.pop_front();
					if (out_data.total_ascent !== want.total_ascent)
						report_mismatch("total_ascent", 64'(out_data.total_ascent),
							64'(want.total_ascent));
					if (out_data.saturated !== want.saturated)
						report_mismatch("saturated", 64'(out_data.saturated),
							64'(want.saturated));
				end
			end
			if (cfg_valid && cfg_ready)
				thr_m = cfg_data;
		end
	end

	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 13);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("hysteresis_ascent_accumulator: mismatch");
			$finish;
		end
	end

	task automatic send_sample(input in_t s, input bit typed, input out_t want);
		out_t pred;
		if (!calm && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (climb_step(s, pred)) begin
			if (typed)
				pred = want;
			totals_q = {totals_q, pred};
		end
	endtask

	// Hold off until every pending total is back and the pipe has emptied.
	task automatic drain();
		in_valid <= 1'b0;
		while (totals_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(input int ele, input bit last, input bit typed,
			input longint total, input bit sat);
		row_t r;
		r.smp.elevation = ele[ELE_W-1:0];
		r.smp.last_sample = last;
		r.typed = typed;
		r.want.total_ascent = total[SUM_W-1:0];
		r.want.saturated = sat;
		rows = {rows, r};
	endtask

	// Random walk around a start level, steps sized to straddle the threshold.
	task automatic send_track(input int n, input longint thr);
		logic signed [ELE_W-1:0] level;
		longint step;
		in_t s;
		if ($urandom_range(7) == 0)
			level = ELE_W'($urandom);
		else
			level = ELE_W'(longint'($urandom_range(11000000)) - 1000000);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(2))
				0: step = thr;
				1: step = thr + 1;
				default: step = longint'($urandom_range(32'(2 * thr + 8)));
			endcase
			if ($urandom_range(1))
				step = -step;
			if (k != 0)
				level = level + step[ELE_W-1:0];
			s.elevation = level;
			if ($urandom_range(9) == 0)
				s.elevation = ELE_W'($urandom);
			s.last_sample = (k == n - 1) || ($urandom_range(39) == 0);
			send_sample(s, 1'b0, '0);
		end
	endtask

	initial begin
		logic [THR_W-1:0] plan[5];
		int sent;
		int n;

		plan[0] = '0;
		plan[1] = {THR_W{1'b1}};
		plan[2] = THR_W'($urandom_range(1000000, 1));
		plan[3] = THR_W'(1);
		plan[4] = THR_RST;

		// single-sample tracks at zero and both extremes
		add_row(0, 1'b1, 1'b1, 0, 1'b0);
		add_row(16777215, 1'b1, 1'b1, 0, 1'b0);
		add_row(-16777216, 1'b1, 1'b1, 0, 1'b0);
		// one climb from -1000000 to 10000000
		add_row(-1000000, 1'b0, 1'b0, 0, 1'b0);
		add_row(10000000, 1'b1, 1'b1, 11000000, 1'b0);
		// change equal to the threshold finds no direction; one past it climbs
		add_row(100, 1'b0, 1'b0, 0, 1'b0);
		add_row(600, 1'b1, 1'b1, 0, 1'b0);
		add_row(100, 1'b0, 1'b0, 0, 1'b0);
		add_row(601, 1'b1, 1'b1, 501, 1'b0);
		// first leg down, then up
		add_row(1000, 1'b0, 1'b0, 0, 1'b0);
		add_row(0, 1'b0, 1'b0, 0, 1'b0);
		add_row(2000, 1'b1, 1'b0, 0, 1'b0);
		// reversals at and just past the threshold
		add_row(0, 1'b0, 1'b0, 0, 1'b0);
		add_row(1000, 1'b0, 1'b0, 0, 1'b0);
		add_row(1200, 1'b0, 1'b0, 0, 1'b0);
		add_row(700, 1'b0, 1'b0, 0, 1'b0);
		add_row(699, 1'b0, 1'b0, 0, 1'b0);
		add_row(800, 1'b0, 1'b0, 0, 1'b0);
		add_row(2000, 1'b1, 1'b0, 0, 1'b0);
		// bottom to top of the 25-bit range
		add_row(-16777216, 1'b0, 1'b0, 0, 1'b0);
		add_row(16777215, 1'b1, 1'b1, 33554431, 1'b0);
		// track ends going down
		add_row(5000, 1'b0, 1'b0, 0, 1'b0);
		add_row(3000, 1'b0, 1'b0, 0, 1'b0);
		add_row(3100, 1'b1, 1'b0, 0, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_sample(rows[i].smp, rows[i].typed, rows[i].want);
		drain();

		foreach (plan[p]) begin
			write_threshold(plan[p]);
			calm = (p == 1);
			sent = 0;
			while (sent < TRACK_BUDGET) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
				send_track(n, longint'(plan[p]));
				sent += n;
				if (p == 2 && sent >= TRACK_BUDGET / 2 && sent - n < TRACK_BUDGET / 2)
					drain();
			end
			drain();
		end
		calm = 1'b0;

		if (errors == 0)
			$display("hysteresis_ascent_accumulator: match");
		else
			$display("hysteresis_ascent_accumulator: mismatch");
		$finish;
	end

endmodule
